// ===== design/hmf_pkg.sv =====
// Shared widths, character codes, result codes and helpers for the HTTP message framer.
package hmf_pkg;

    localparam int DEF_MAX_HEADER_LENGTH = 4096;
    localparam int DEF_MAX_VALUE_CHARS   = 32;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int METHOD_W = 3;
    localparam int HLEN_W   = 13;
    localparam int LEN_W    = 31;
    localparam int SEEN_W   = 32;
    localparam int ACC_W    = 32;
    localparam int NAME_W   = 5;
    localparam int HDR_KEY_LEN = 17;

    localparam logic [ACC_W-1:0] VALUE_CAP = 32'h8000_0000;
    localparam logic [ACC_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
    localparam logic [LEN_W-1:0] MAX_MSG_RESET = 31'h7FFF_FFFF;

    localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_VT  = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FF  = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_COMPLETE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_LENGTH  = 2'd3;

    localparam logic [METHOD_W-1:0] MK_UNKNOWN  = 3'd0;
    localparam logic [METHOD_W-1:0] MK_GET      = 3'd1;
    localparam logic [METHOD_W-1:0] MK_POST     = 3'd2;
    localparam logic [METHOD_W-1:0] MK_HEAD     = 3'd3;
    localparam logic [METHOD_W-1:0] MK_RESPONSE = 3'd4;

    typedef logic [3:0][BYTE_W-1:0] method_buf_t;

    function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    // lower-case "\r\nContent-Length:"
    function automatic logic [BYTE_W-1:0] name_char(input logic [NAME_W-1:0] idx);
        logic [BYTE_W-1:0] ch;
        case (idx)
            5'd0:    ch = CH_CR;
            5'd1:    ch = CH_LF;
            5'd2:    ch = 8'h63;
            5'd3:    ch = 8'h6F;
            5'd4:    ch = 8'h6E;
            5'd5:    ch = 8'h74;
            5'd6:    ch = 8'h65;
            5'd7:    ch = 8'h6E;
            5'd8:    ch = 8'h74;
            5'd9:    ch = 8'h2D;
            5'd10:   ch = 8'h6C;
            5'd11:   ch = 8'h65;
            5'd12:   ch = 8'h6E;
            5'd13:   ch = 8'h67;
            5'd14:   ch = 8'h74;
            5'd15:   ch = 8'h68;
            5'd16:   ch = 8'h3A;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // CR LF CR LF
    function automatic logic [BYTE_W-1:0] blank_char(input logic [1:0] idx);
        return idx[0] ? CH_LF : CH_CR;
    endfunction

    function automatic logic [METHOD_W-1:0] classify(input method_buf_t mb);
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        logic [BYTE_W-1:0] b3;
        logic [METHOD_W-1:0] kind;
        b0 = to_lower(mb[0]);
        b1 = to_lower(mb[1]);
        b2 = to_lower(mb[2]);
        b3 = to_lower(mb[3]);
        if (b0 == 8'h67 && b1 == 8'h65 && b2 == 8'h74)
            kind = MK_GET;
        else if (b0 == 8'h70 && b1 == 8'h6F && b2 == 8'h73 && b3 == 8'h74)
            kind = MK_POST;
        else if (b0 == 8'h68 && b1 == 8'h65 && b2 == 8'h61 && b3 == 8'h64)
            kind = MK_HEAD;
        else if (b0 == 8'h68 && b1 == 8'h74 && b2 == 8'h74 && b3 == 8'h70)
            kind = MK_RESPONSE;
        else
            kind = MK_UNKNOWN;
        return kind;
    endfunction

endpackage

// ===== design/http_message_framer.sv =====
// Top level of the HTTP message framer: byte-serial header scan and length framing.
// Result path: the accepted byte is held in an input register, and its result in a result register.
// Throughput: one byte per cycle while out_ready is not held low; the next item is taken while a result waits.
// Reset (rst_n low, asynchronous): tracking state cleared, pipeline emptied,
// max_message_length returns to 2147483647. No clearing pass.
module http_message_framer
    import hmf_pkg::*;
#(
    parameter int MAX_HEADER_LENGTH = DEF_MAX_HEADER_LENGTH,
    parameter int MAX_VALUE_CHARS   = DEF_MAX_VALUE_CHARS
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [LEN_W-1:0]    cfg_data,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [BYTE_W-1:0]   msg_byte,
    input  logic                first_byte,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] frame_status,
    output logic [METHOD_W-1:0] method_kind,
    output logic [HLEN_W-1:0]   header_length,
    output logic [LEN_W-1:0]    body_length,
    output logic [LEN_W-1:0]    total_length
);

    localparam int HE_W = $clog2(MAX_HEADER_LENGTH + 1);
    localparam int VC_W = $clog2(MAX_VALUE_CHARS + 2);
    localparam logic [SEEN_W-1:0] HDR_LIMIT = SEEN_W'(MAX_HEADER_LENGTH - 1);
    localparam logic [HE_W-1:0]   HE_LIMIT  = HE_W'(MAX_HEADER_LENGTH - 1);
    localparam logic [VC_W-1:0]   VC_CAP    = VC_W'(MAX_VALUE_CHARS);
    localparam logic [VC_W-1:0]   VC_LIMIT  = VC_W'(MAX_VALUE_CHARS - 1);

    localparam logic [2:0] PH_SEARCH  = 3'd0;
    localparam logic [2:0] PH_BLANKS  = 3'd1;
    localparam logic [2:0] PH_SPACE   = 3'd2;
    localparam logic [2:0] PH_SIGN    = 3'd3;
    localparam logic [2:0] PH_DIGITS  = 3'd4;
    localparam logic [2:0] PH_TRAIL   = 3'd5;
    localparam logic [2:0] PH_NODIGIT = 3'd6;
    localparam logic [2:0] PH_DONE    = 3'd7;

    logic [LEN_W-1:0]    max_len_reg;

    logic                s1_valid_reg;
    logic [BYTE_W-1:0]   s1_byte_reg;
    logic                s1_first_reg;

    logic [SEEN_W-1:0]   seen_reg,    seen_next;
    method_buf_t         mbuf_reg,    mbuf_next;
    logic [1:0]          blank_reg,   blank_next;
    logic [HE_W-1:0]     hend_reg,    hend_next;
    logic [NAME_W-1:0]   nmatch_reg,  nmatch_next;
    logic [2:0]          phase_reg,   phase_next;
    logic [VC_W-1:0]     vchars_reg,  vchars_next;
    logic [ACC_W-1:0]    acc_reg,     acc_next;
    logic [STATUS_W-1:0] sticky_reg,  sticky_next;
    logic                neg_reg,     neg_next;
    logic                good_reg,    good_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg,  status_next;
    logic [METHOD_W-1:0] method_reg,  method_next;
    logic [HLEN_W-1:0]   hlen_reg,    hlen_next;
    logic [LEN_W-1:0]    body_reg,    body_next;
    logic [LEN_W-1:0]    total_reg,   total_next;

    logic advance;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        logic [SEEN_W-1:0]   cur_seen;
        method_buf_t         cur_mbuf;
        logic [1:0]          cur_blank;
        logic [HE_W-1:0]     cur_hend;
        logic [NAME_W-1:0]   cur_nmatch;
        logic [2:0]          cur_phase;
        logic [VC_W-1:0]     cur_vchars;
        logic [ACC_W-1:0]    cur_acc;
        logic [STATUS_W-1:0] cur_sticky;
        logic                cur_neg;
        logic [BYTE_W-1:0]   c;
        logic                prev_cr;
        logic                is_blank;
        logic                is_ws;
        logic                is_sign;
        logic                is_digit;
        logic [VC_W-1:0]     vlen;
        logic [34:0]         prod;
        logic [2:0]          bcount;
        logic [SEEN_W-1:0]   len;
        logic [32:0]         sum;

        // first_byte clears tracking before the byte is taken
        cur_seen   = s1_first_reg ? '0 : seen_reg;
        cur_mbuf   = s1_first_reg ? '0 : mbuf_reg;
        cur_blank  = s1_first_reg ? '0 : blank_reg;
        cur_hend   = s1_first_reg ? '0 : hend_reg;
        cur_nmatch = s1_first_reg ? '0 : nmatch_reg;
        cur_phase  = s1_first_reg ? PH_SEARCH : phase_reg;
        cur_vchars = s1_first_reg ? '0 : vchars_reg;
        cur_acc    = s1_first_reg ? '0 : acc_reg;
        cur_sticky = s1_first_reg ? ST_INCOMPLETE : sticky_reg;
        cur_neg    = s1_first_reg ? 1'b0 : neg_reg;

        c        = s1_byte_reg;
        is_blank = (c == CH_SP) || (c == CH_TAB);
        is_ws    = (c == CH_LF) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
        is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        prod     = 35'(cur_acc) * 35'd10 + 35'(c[3:0]);
        prev_cr  = cur_blank[0];
        vlen     = (cur_vchars != '0) ? cur_vchars - 1'b1 : '0;
        bcount   = '0;

        mbuf_next = cur_mbuf;
        if (cur_seen < SEEN_W'(4))
            mbuf_next[cur_seen[1:0]] = cur_mbuf[cur_seen[1:0]] | c;
        seen_next = (cur_seen != '1) ? cur_seen + 1'b1 : cur_seen;
        len       = seen_next;

        blank_next  = cur_blank;
        hend_next   = cur_hend;
        nmatch_next = cur_nmatch;
        phase_next  = cur_phase;
        vchars_next = cur_vchars;
        acc_next    = cur_acc;
        neg_next    = cur_neg;
        good_next   = s1_first_reg ? 1'b0 : good_reg;

        if (cur_sticky == ST_INCOMPLETE && cur_hend == '0)
        begin
            if (cur_phase >= PH_BLANKS && cur_phase <= PH_NODIGIT)
            begin
                if (c == CH_LF && prev_cr)
                begin
                    good_next  = (cur_phase == PH_DIGITS || cur_phase == PH_TRAIL)
                                 && vlen <= VC_LIMIT
                                 && !(cur_neg && cur_acc != '0)
                                 && cur_acc <= VALUE_MAX;
                    phase_next = PH_DONE;
                end
                else
                begin
                    if (cur_vchars <= VC_CAP)
                        vchars_next = cur_vchars + 1'b1;
                    unique case (cur_phase) inside
                        PH_BLANKS, PH_SPACE:
                        begin
                            if (is_blank)
                                phase_next = (cur_phase == PH_BLANKS) ? PH_BLANKS : PH_NODIGIT;
                            else if (is_ws)
                                phase_next = PH_SPACE;
                            else if (is_sign)
                            begin
                                neg_next   = (c == CH_MINUS);
                                phase_next = PH_SIGN;
                            end
                            else if (is_digit)
                            begin
                                acc_next   = (prod >= 35'(VALUE_CAP)) ? VALUE_CAP : prod[31:0];
                                phase_next = PH_DIGITS;
                            end
                            else
                                phase_next = PH_NODIGIT;
                        end
                        PH_SIGN:
                        begin
                            if (is_digit)
                            begin
                                acc_next   = (prod >= 35'(VALUE_CAP)) ? VALUE_CAP : prod[31:0];
                                phase_next = PH_DIGITS;
                            end
                            else
                                phase_next = PH_NODIGIT;
                        end
                        PH_DIGITS:
                        begin
                            if (is_digit)
                                acc_next = (prod >= 35'(VALUE_CAP)) ? VALUE_CAP : prod[31:0];
                            else
                                phase_next = PH_TRAIL;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            else if (cur_phase == PH_SEARCH)
            begin
                if (to_lower(c) == name_char(cur_nmatch))
                begin
                    if (cur_nmatch == NAME_W'(HDR_KEY_LEN - 1))
                    begin
                        nmatch_next = '0;
                        phase_next  = PH_BLANKS;
                        vchars_next = '0;
                        acc_next    = '0;
                        neg_next    = 1'b0;
                    end
                    else
                        nmatch_next = cur_nmatch + 1'b1;
                end
                else
                    nmatch_next = (c == CH_CR) ? NAME_W'(1) : '0;
            end

            if (c == blank_char(cur_blank))
                bcount = {1'b0, cur_blank} + 3'd1;
            else
                bcount = (c == CH_CR) ? 3'd1 : 3'd0;
            if (bcount[2])
            begin
                blank_next = '0;
                hend_next  = HE_W'(len);
            end
            else
                blank_next = bcount[1:0];
        end

        // verdict on the prefix so far; the value is never finished and extended
        // in the same byte, so the stored accumulator is the final one here
        sum         = 33'(hend_next) + 33'(cur_acc);
        status_next = ST_INCOMPLETE;
        method_next = MK_UNKNOWN;
        hlen_next   = '0;
        body_next   = '0;
        total_next  = '0;
        if (len >= SEEN_W'(4))
        begin
            method_next = classify(mbuf_next);
            if (method_next == MK_UNKNOWN)
                status_next = ST_ERROR;
            else if (hend_next == '0 || hend_next > HE_LIMIT)
            begin
                if (hend_next != '0 || len > HDR_LIMIT)
                    status_next = ST_ERROR;
            end
            else
            begin
                hlen_next = HLEN_W'(hend_next);
                if (method_next == MK_GET || method_next == MK_HEAD)
                begin
                    status_next = ST_COMPLETE;
                    total_next  = LEN_W'(hend_next);
                end
                else if (phase_next == PH_SEARCH)
                    status_next = ST_NO_LENGTH;
                else if (phase_next != PH_DONE || !good_next)
                    status_next = ST_ERROR;
                else
                begin
                    body_next = cur_acc[LEN_W-1:0];
                    if (sum > 33'(max_len_reg))
                        status_next = ST_ERROR;
                    else if (33'(len) >= sum)
                    begin
                        status_next = ST_COMPLETE;
                        total_next  = sum[LEN_W-1:0];
                    end
                end
            end
        end

        sticky_next = (status_next == ST_ERROR || status_next == ST_NO_LENGTH)
                      ? status_next : cur_sticky;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_MSG_RESET;
        else if (cfg_valid && cfg_ready)
            max_len_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seen_reg      <= '0;
            mbuf_reg      <= '0;
            blank_reg     <= '0;
            hend_reg      <= '0;
            nmatch_reg    <= '0;
            phase_reg     <= PH_SEARCH;
            vchars_reg    <= '0;
            acc_reg       <= '0;
            sticky_reg    <= ST_INCOMPLETE;
            neg_reg       <= 1'b0;
            good_reg      <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                seen_reg   <= seen_next;
                mbuf_reg   <= mbuf_next;
                blank_reg  <= blank_next;
                hend_reg   <= hend_next;
                nmatch_reg <= nmatch_next;
                phase_reg  <= phase_next;
                vchars_reg <= vchars_next;
                acc_reg    <= acc_next;
                sticky_reg <= sticky_next;
                neg_reg    <= neg_next;
                good_reg   <= good_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg  <= msg_byte;
            s1_first_reg <= first_byte;
        end
        if (advance)
        begin
            status_reg <= status_next;
            method_reg <= method_next;
            hlen_reg   <= hlen_next;
            body_reg   <= body_next;
            total_reg  <= total_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_status  = status_reg;
    assign method_kind   = method_reg;
    assign header_length = hlen_reg;
    assign body_length   = body_reg;
    assign total_length  = total_reg;

endmodule
